// ===== rtl/la_bbox_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// la_bbox_pkg
// Constants, register codes and size helpers for the luma-to-alpha
// bounding box block.
// ----------------------------------------------------------------------------
package la_bbox_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WSIZE_W = $clog2(MAX_WIDTH + 1);
  localparam int HSIZE_W = $clog2(MAX_HEIGHT + 1);

  localparam int CFG_SIZE_W = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int THR_W      = 8;
  localparam int PIX_W      = 8;
  localparam int ALPHA_W    = 8;
  localparam int BOX_W      = 12;
  localparam int COUNT_W    = 25;
  localparam int LUM_W      = 24;

  localparam int WCMP_W = (CFG_SIZE_W > WSIZE_W) ? CFG_SIZE_W : WSIZE_W;
  localparam int HCMP_W = (CFG_SIZE_W > HSIZE_W) ? CFG_SIZE_W : HSIZE_W;

  // rec.709 weights in q16, summing to 65536
  localparam logic [LUM_W-1:0] COEF_R = LUM_W'(13933);
  localparam logic [LUM_W-1:0] COEF_G = LUM_W'(46871);
  localparam logic [LUM_W-1:0] COEF_B = LUM_W'(4732);
  // 255 in q16 plus one half for rounding
  localparam logic [LUM_W-1:0] ALPHA_BIAS = LUM_W'(255 * 65536 + 32768);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CFG_SIZE_W-1:0] WIDTH_RESET  = CFG_SIZE_W'(4096);
  localparam logic [CFG_SIZE_W-1:0] HEIGHT_RESET = CFG_SIZE_W'(4096);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_ALPHA_CUTOFF = 2'd2
  } cfg_index_t;

  function automatic logic [WSIZE_W-1:0] clamp_width(input logic [CFG_SIZE_W-1:0] v);
    logic [WSIZE_W-1:0] r;
    if (v == '0) begin
      r = WSIZE_W'(1);
    end else if (WCMP_W'(v) > WCMP_W'(MAX_WIDTH)) begin
      r = WSIZE_W'(MAX_WIDTH);
    end else begin
      r = WSIZE_W'(v);
    end
    return r;
  endfunction

  function automatic logic [HSIZE_W-1:0] clamp_height(input logic [CFG_SIZE_W-1:0] v);
    logic [HSIZE_W-1:0] r;
    if (v == '0) begin
      r = HSIZE_W'(1);
    end else if (HCMP_W'(v) > HCMP_W'(MAX_HEIGHT)) begin
      r = HSIZE_W'(MAX_HEIGHT);
    end else begin
      r = HSIZE_W'(v);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/luma_to_alpha_bounding_box.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// luma_to_alpha_bounding_box
// Turns rgb pixels into inverted rec.709 luma alpha with a threshold and
// keeps per-frame peak, nonzero count and bounding box of nonzero pixels.
//
//   channel   direction  handshake                 payload
//   input     in         in_valid / in_stall       red, green, blue
//   output    out        out_valid / out_stall     alpha_value .. nonzero_count
//   config    in         cfg_write                 cfg_index, cfg_data
//
// One beat per cycle sustained while out_stall is low.
// Stage one computes alpha, stage two updates position and frame statistics
// and holds the result register.
// in_stall follows out_stall when both stages are full.
// Synchronous reset clears config, positions and statistics; 4096 x 4096
// pixels per frame after reset.
// ----------------------------------------------------------------------------
module luma_to_alpha_bounding_box
  import la_bbox_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [PIX_W-1:0]      red,
  input  wire logic [PIX_W-1:0]      green,
  input  wire logic [PIX_W-1:0]      blue,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [ALPHA_W-1:0]         alpha_value,
  output logic                       frame_end,
  output logic                       content_found,
  output logic [BOX_W-1:0]           box_left,
  output logic [BOX_W-1:0]           box_top,
  output logic [BOX_W-1:0]           box_right,
  output logic [BOX_W-1:0]           box_bottom,
  output logic [ALPHA_W-1:0]         peak_alpha,
  output logic [COUNT_W-1:0]         nonzero_count
);

  logic [CFG_SIZE_W-1:0] frame_width;
  logic [CFG_SIZE_W-1:0] frame_height;
  logic [THR_W-1:0]      alpha_cutoff;

  logic                  s1_valid;
  logic [ALPHA_W-1:0]    s1_alpha;
  logic                  s2_load;
  logic                  in_take;
  logic                  s1_move;

  logic [LUM_W-1:0]      lum;
  logic [LUM_W-1:0]      inv_lum;
  logic [ALPHA_W-1:0]    alpha_raw;
  logic [ALPHA_W-1:0]    alpha_next;

  logic [COL_W-1:0]      column_position;
  logic [ROW_W-1:0]      row_position;
  logic [COL_W-1:0]      min_column;
  logic [ROW_W-1:0]      min_row;
  logic [COL_W-1:0]      max_column;
  logic [ROW_W-1:0]      max_row;
  logic                  content_seen;
  logic [ALPHA_W-1:0]    peak_seen;
  logic [COUNT_W-1:0]    count_seen;

  logic [COL_W-1:0]      column_position_next;
  logic [ROW_W-1:0]      row_position_next;
  logic [COL_W-1:0]      min_column_next;
  logic [ROW_W-1:0]      min_row_next;
  logic [COL_W-1:0]      max_column_next;
  logic [ROW_W-1:0]      max_row_next;
  logic                  content_seen_next;
  logic [ALPHA_W-1:0]    peak_seen_next;
  logic [COUNT_W-1:0]    count_seen_next;

  logic [WSIZE_W-1:0]    width_eff;
  logic [HSIZE_W-1:0]    height_eff;
  logic                  row_end;
  logic                  frame_last;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      alpha_cutoff <= '0;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_FRAME_WIDTH:  frame_width  <= CFG_SIZE_W'(cfg_data);
        CFG_FRAME_HEIGHT: frame_height <= CFG_SIZE_W'(cfg_data);
        CFG_ALPHA_CUTOFF: alpha_cutoff <= cfg_data[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // handshake
  assign s2_load  = !out_valid || !out_stall;
  assign s1_move  = s1_valid && s2_load;
  assign in_stall = s1_valid && !s2_load;
  assign in_take  = in_valid && !in_stall;

  // stage one: alpha
  always_comb begin
    lum = COEF_R * LUM_W'(red) + COEF_G * LUM_W'(green) + COEF_B * LUM_W'(blue);
    inv_lum = ALPHA_BIAS - lum;
    alpha_raw = inv_lum[LUM_W-1 -: ALPHA_W];
    alpha_next = (alpha_raw <= alpha_cutoff) ? '0 : alpha_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_alpha <= alpha_next;
    end
  end

  // stage two: position and frame statistics
  always_comb begin
    width_eff  = clamp_width(frame_width);
    height_eff = clamp_height(frame_height);
    row_end    = (WSIZE_W'(column_position) + WSIZE_W'(1)) >= width_eff;
    frame_last = row_end && ((HSIZE_W'(row_position) + HSIZE_W'(1)) >= height_eff);

    min_column_next   = min_column;
    min_row_next      = min_row;
    max_column_next   = max_column;
    max_row_next      = max_row;
    content_seen_next = content_seen;
    count_seen_next   = count_seen;
    peak_seen_next    = (s1_alpha > peak_seen) ? s1_alpha : peak_seen;

    if (s1_alpha != '0) begin
      if (count_seen != COUNT_MAX) begin
        count_seen_next = count_seen + COUNT_W'(1);
      end
      content_seen_next = 1'b1;
      if (!content_seen) begin
        min_column_next = column_position;
        min_row_next    = row_position;
        max_column_next = column_position;
        max_row_next    = row_position;
      end else begin
        if (column_position < min_column) min_column_next = column_position;
        if (row_position < min_row)       min_row_next    = row_position;
        if (column_position > max_column) max_column_next = column_position;
        if (row_position > max_row)       max_row_next    = row_position;
      end
    end

    if (row_end) begin
      column_position_next = '0;
      row_position_next    = frame_last ? '0 : row_position + ROW_W'(1);
    end else begin
      column_position_next = column_position + COL_W'(1);
      row_position_next    = row_position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
      min_column      <= COL_W'(MAX_WIDTH - 1);
      min_row         <= ROW_W'(MAX_HEIGHT - 1);
      max_column      <= '0;
      max_row         <= '0;
      content_seen    <= 1'b0;
      peak_seen       <= '0;
      count_seen      <= '0;
    end else if (s1_move) begin
      column_position <= column_position_next;
      row_position    <= row_position_next;
      if (frame_last) begin
        min_column   <= COL_W'(MAX_WIDTH - 1);
        min_row      <= ROW_W'(MAX_HEIGHT - 1);
        max_column   <= '0;
        max_row      <= '0;
        content_seen <= 1'b0;
        peak_seen    <= '0;
        count_seen   <= '0;
      end else begin
        min_column   <= min_column_next;
        min_row      <= min_row_next;
        max_column   <= max_column_next;
        max_row      <= max_row_next;
        content_seen <= content_seen_next;
        peak_seen    <= peak_seen_next;
        count_seen   <= count_seen_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      alpha_value   <= s1_alpha;
      frame_end     <= frame_last;
      content_found <= content_seen_next;
      box_left      <= content_seen_next ? BOX_W'(min_column_next) : '0;
      box_top       <= content_seen_next ? BOX_W'(min_row_next) : '0;
      box_right     <= content_seen_next ? BOX_W'(max_column_next) : '0;
      box_bottom    <= content_seen_next ? BOX_W'(max_row_next) : '0;
      peak_alpha    <= peak_seen_next;
      nonzero_count <= count_seen_next;
    end
  end

`ifndef SYNTHESIS
  a_content_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (content_found == (nonzero_count != '0)))
    else $error("content flag disagrees with nonzero count");

  a_box_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && content_found) |-> (box_left <= box_right && box_top <= box_bottom))
    else $error("bounding box corners out of order");

  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (alpha_value <= peak_alpha))
    else $error("alpha beat above frame peak");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a full pipeline");
`endif

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for luma_to_alpha_bounding_box. Pixels are streamed
// through the valid/stall input with random gaps while the result side
// stalls at random and once holds off long enough to back the block up.
// A behavioral alpha and frame-statistics tracker predicts every result beat,
// which is checked field by field. Covers reset sizes, threshold extremes,
// out-of-range sizes, size changes in the middle of a frame, sizes clamped
// to the maximum and randomized small frames.
// ----------------------------------------------------------------------------
module tb;
  import la_bbox_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
  } pixel_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic               last;
    logic               lit;
    logic [BOX_W-1:0]   left;
    logic [BOX_W-1:0]   top;
    logic [BOX_W-1:0]   right;
    logic [BOX_W-1:0]   bottom;
    logic [ALPHA_W-1:0] peak;
    logic [COUNT_W-1:0] count;
  } alpha_stats_t;

  localparam int QUIET_START = 250;
  localparam int QUIET_END   = 400;
  localparam int HOLD_CYCLES = 80;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PIX_W-1:0]      red = '0;
  logic [PIX_W-1:0]      green = '0;
  logic [PIX_W-1:0]      blue = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ALPHA_W-1:0]    alpha_value;
  logic                  frame_end;
  logic                  content_found;
  logic [BOX_W-1:0]      box_left;
  logic [BOX_W-1:0]      box_top;
  logic [BOX_W-1:0]      box_right;
  logic [BOX_W-1:0]      box_bottom;
  logic [ALPHA_W-1:0]    peak_alpha;
  logic [COUNT_W-1:0]    nonzero_count;

  luma_to_alpha_bounding_box DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .red(red),
    .green(green),
    .blue(blue),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .alpha_value(alpha_value),
    .frame_end(frame_end),
    .content_found(content_found),
    .box_left(box_left),
    .box_top(box_top),
    .box_right(box_right),
    .box_bottom(box_bottom),
    .peak_alpha(peak_alpha),
    .nonzero_count(nonzero_count)
  );

  // tracker copy of registers and frame statistics
  logic [CFG_SIZE_W-1:0] width_reg = WIDTH_RESET;
  logic [CFG_SIZE_W-1:0] height_reg = HEIGHT_RESET;
  logic [THR_W-1:0]      thresh_reg = '0;
  logic [BOX_W-1:0]      col_pos = '0;
  logic [BOX_W-1:0]      row_pos = '0;
  logic [BOX_W-1:0]      lo_col = BOX_W'(MAX_WIDTH - 1);
  logic [BOX_W-1:0]      lo_row = BOX_W'(MAX_HEIGHT - 1);
  logic [BOX_W-1:0]      hi_col = '0;
  logic [BOX_W-1:0]      hi_row = '0;
  logic                  lit_seen = 1'b0;
  logic [ALPHA_W-1:0]    peak_seen = '0;
  logic [COUNT_W-1:0]    lit_count = '0;

  pixel_t       pixels_to_send[$];
  alpha_stats_t stats_due[$];
  pixel_t       next_px;
  alpha_stats_t due;

  int  mismatches = 0;
  int  cycle_count = 0;
  int  results_seen = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  logic beat_in = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("luma_to_alpha_bounding_box regression: fail");
    $finish;
  end

  function automatic int unsigned used_size(logic [CFG_SIZE_W-1:0] v, int unsigned maxv);
    if (v == '0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic bit idle_roll();
    return (cycle_count < QUIET_START || cycle_count >= QUIET_END) &&
           ($urandom_range(99) < 23);
  endfunction

  task automatic predict_pixel(input logic [PIX_W-1:0] r, g, b);
    int unsigned lum, a, w, h;
    bit row_done, frame_done;
    alpha_stats_t s;
    w = used_size(width_reg, MAX_WIDTH);
    h = used_size(height_reg, MAX_HEIGHT);
    lum = COEF_R * r + COEF_G * g + COEF_B * b;
    a = (255 * 65536 + 32768 - lum) >> 16;
    if (a > 255) a = 255;
    if (a <= thresh_reg) a = 0;
    if (a > peak_seen) peak_seen = a;
    if (a != 0) begin
      if (lit_count != COUNT_MAX) lit_count = lit_count + 1'b1;
      if (!lit_seen) begin
        lo_col = col_pos;
        lo_row = row_pos;
        hi_col = col_pos;
        hi_row = row_pos;
        lit_seen = 1'b1;
      end else begin
        if (col_pos < lo_col) lo_col = col_pos;
        if (row_pos < lo_row) lo_row = row_pos;
        if (col_pos > hi_col) hi_col = col_pos;
        if (row_pos > hi_row) hi_row = row_pos;
      end
    end
    row_done = (col_pos + 1 >= w);
    frame_done = row_done && (row_pos + 1 >= h);
    s.alpha = a;
    s.last = frame_done;
    s.lit = lit_seen;
    s.left = lit_seen ? lo_col : '0;
    s.top = lit_seen ? lo_row : '0;
    s.right = lit_seen ? hi_col : '0;
    s.bottom = lit_seen ? hi_row : '0;
    s.peak = peak_seen;
    s.count = lit_count;
    stats_due.push_back(s);
    if (row_done) begin
      col_pos = '0;
      if (frame_done) begin
        row_pos = '0;
        lo_col = BOX_W'(MAX_WIDTH - 1);
        lo_row = BOX_W'(MAX_HEIGHT - 1);
        hi_col = '0;
        hi_row = '0;
        lit_seen = 1'b0;
        peak_seen = '0;
        lit_count = '0;
      end else begin
        row_pos = row_pos + 1'b1;
      end
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // sample handshakes, predict accepted pixels, check result beats
  always @(posedge clk) begin
    if (!rst) begin
      cycle_count <= cycle_count + 1;
      beat_in <= in_valid && !in_stall;
      if (in_valid && !in_stall) predict_pixel(red, green, blue);
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (stats_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 40)
            $display("%0t unexpected result beat: expected none, actual alpha %0d",
                     $time, alpha_value);
        end else begin
          due = stats_due.pop_front();
          check_field("alpha_value", due.alpha, alpha_value);
          check_field("frame_end", due.last, frame_end);
          check_field("content_found", due.lit, content_found);
          check_field("box_left", due.left, box_left);
          check_field("box_top", due.top, box_top);
          check_field("box_right", due.right, box_right);
          check_field("box_bottom", due.bottom, box_bottom);
          check_field("peak_alpha", due.peak, peak_alpha);
          check_field("nonzero_count", due.count, nonzero_count);
        end
      end
    end
  end

  // pixel driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || beat_in) begin
      if (pixels_to_send.size() != 0 && !idle_roll()) begin
        next_px = pixels_to_send.pop_front();
        in_valid <= 1'b1;
        red <= next_px.r;
        green <= next_px.g;
        blue <= next_px.b;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side stall, with one long hold-off to back up the pipe
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 100) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= idle_roll();
    end
  end

  task automatic push_px(input int r, g, b);
    pixel_t p;
    p.r = r;
    p.g = g;
    p.b = b;
    pixels_to_send.push_back(p);
  endtask

  task automatic push_random(input int n, input int dark_pct);
    int roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < dark_pct)
        push_px($urandom_range(255), $urandom_range(255), $urandom_range(255));
      else if (roll < dark_pct + 8)
        push_px(0, 0, 0);
      else
        push_px($urandom_range(230, 255), $urandom_range(230, 255), $urandom_range(230, 255));
    end
  endtask

  // wait for the pipe to drain and the expected results to be checked
  task automatic settle();
    while (pixels_to_send.size() != 0 || in_valid || stats_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH: width_reg = data;
      CFG_FRAME_HEIGHT: height_reg = data;
      CFG_ALPHA_CUTOFF: thresh_reg = data[THR_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_size();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return $urandom_range(4097, 8191);
    return $urandom_range(1, 12);
  endfunction

  initial begin
    int tie_r, tie_g, tie_b;
    bit tie_found;
    logic [CFG_DATA_W-1:0] thr_data;

    // find an exact rounding tie for the directed part
    tie_found = 1'b0;
    tie_r = 0;
    tie_g = 0;
    tie_b = 0;
    for (int r = 0; r < 256 && !tie_found; r++)
      for (int g = 0; g < 256 && !tie_found; g++)
        for (int b = 0; b < 256 && !tie_found; b++)
          if (((13933 * r + 46871 * g + 4732 * b) % 65536) == 32768) begin
            tie_found = 1'b1;
            tie_r = r;
            tie_g = g;
            tie_b = b;
          end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset sizes and threshold: primaries, black, white, grey, rounding tie
    push_px(0, 0, 0);
    push_px(255, 255, 255);
    push_px(255, 0, 0);
    push_px(0, 255, 0);
    push_px(0, 0, 255);
    push_px(128, 128, 128);
    if (tie_found) push_px(tie_r, tie_g, tie_b);
    settle();

    // threshold at max, upper data bits set: nothing survives
    write_reg(CFG_FRAME_WIDTH, 3);
    write_reg(CFG_FRAME_HEIGHT, 2);
    write_reg(CFG_ALPHA_CUTOFF, 13'h1F00 | 13'd255);
    push_px(0, 0, 0);
    push_px(0, 0, 0);
    push_px(0, 0, 0);
    settle();

    write_reg(CFG_ALPHA_CUTOFF, 100);
    push_px(255, 255, 255);
    push_px(0, 0, 0);
    push_px(200, 200, 200);
    push_px(0, 0, 0);
    push_px(90, 90, 90);
    push_px(255, 255, 255);
    settle();

    // zero sizes act as one pixel frames
    write_reg(CFG_FRAME_WIDTH, 0);
    write_reg(CFG_FRAME_HEIGHT, 0);
    write_reg(CFG_ALPHA_CUTOFF, 0);
    push_px(0, 0, 0);
    push_px(255, 255, 255);
    push_px(10, 20, 30);
    settle();

    // shrink the width in the middle of a frame
    write_reg(CFG_FRAME_WIDTH, 8);
    write_reg(CFG_FRAME_HEIGHT, 4);
    push_random(5, 50);
    settle();
    write_reg(CFG_FRAME_WIDTH, 2);
    push_random(4, 50);
    settle();

    // oversized width, then oversized height, both clamped to the maximum
    write_reg(CFG_FRAME_WIDTH, 8191);
    write_reg(CFG_FRAME_HEIGHT, 1);
    push_random(20, 4);
    settle();
    write_reg(CFG_FRAME_WIDTH, 1);
    write_reg(CFG_FRAME_HEIGHT, 4097);
    push_random(20, 4);
    settle();

    for (int ph = 0; ph < 9; ph++) begin
      write_reg(CFG_FRAME_WIDTH, rand_size());
      write_reg(CFG_FRAME_HEIGHT, rand_size());
      if (ph == 0) thr_data = 0;
      else if (ph == 1) thr_data = 255;
      else thr_data = $urandom_range(0, 200);
      thr_data[CFG_DATA_W-1:THR_W] = $urandom();
      write_reg(CFG_ALPHA_CUTOFF, thr_data);
      push_random($urandom_range(32, 52), $urandom_range(20, 60));
      settle();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && stats_due.size() == 0) begin
      $display("luma_to_alpha_bounding_box regression: pass");
    end else begin
      $display("luma_to_alpha_bounding_box regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/la_bbox_pkg.sv
rtl/luma_to_alpha_bounding_box.sv
verif/tb.sv
